/* rtl/krt_pkg.sv */
// Shared types and codes for the keyed record table.
package krt_pkg;

  localparam int KEY_W  = 32;
  localparam int DATA_W = 64;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_UPDATE = 2'd1,
    OP_DELETE = 2'd2,
    OP_FIND   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_FULL     = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE    = 2'd0,
    S_MATCH   = 2'd1,
    S_RESOLVE = 2'd2,
    S_EXEC    = 2'd3
  } state_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    op_t  op;
    logic capture;  // latch key compare result
    logic commit;   // apply the operation to the stored entry
  } cell_ctl_t;

endpackage

/* rtl/krt_in_if.sv */
// Command channel: valid/ready handshake with command payload.
interface krt_in_if;
  import krt_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [1:0]               command;
  logic signed [KEY_W-1:0]  record_key;
  logic [DATA_W-1:0]        name_data;
  logic [DATA_W-1:0]        description_data;

  modport source (output valid, command, record_key, name_data, description_data,
                  input ready);
  modport sink   (input valid, command, record_key, name_data, description_data,
                  output ready);
endinterface

/* rtl/krt_out_if.sv */
// Result channel: valid/ready handshake with status and lookup payload.
interface krt_out_if #(
  parameter int POS_W = 6,
  parameter int CNT_W = 7
);
  import krt_pkg::*;

  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic [POS_W-1:0]  position;
  logic [DATA_W-1:0] found_name;
  logic [DATA_W-1:0] found_description;
  logic [CNT_W-1:0]  entry_total;

  modport source (output valid, status, position, found_name, found_description,
                  entry_total, input ready);
  modport sink   (input valid, status, position, found_name, found_description,
                  entry_total, output ready);
endinterface

/* rtl/krt_cell.sv */
// One table slot: stores a record, compares the key, appends, updates or shifts down.
module krt_cell #(
  parameter int CNT_W    = 7,
  parameter int POS_W    = 6,
  parameter int CELL_IDX = 0
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  krt_pkg::cell_ctl_t        ctl,
  input  logic [krt_pkg::KEY_W-1:0] cmd_key,
  input  logic [krt_pkg::DATA_W-1:0] cmd_name,
  input  logic [krt_pkg::DATA_W-1:0] cmd_desc,
  input  logic [CNT_W-1:0]          count,
  input  logic [POS_W-1:0]          hit_pos,
  input  logic [krt_pkg::KEY_W-1:0] nb_key,
  input  logic [krt_pkg::DATA_W-1:0] nb_name,
  input  logic [krt_pkg::DATA_W-1:0] nb_desc,
  output logic [krt_pkg::KEY_W-1:0] key,
  output logic [krt_pkg::DATA_W-1:0] name,
  output logic [krt_pkg::DATA_W-1:0] desc,
  output logic                      match
);
  import krt_pkg::*;

  localparam logic [CNT_W:0] IDX  = (CNT_W+1)'(CELL_IDX);
  localparam logic [CNT_W:0] NEXT = (CNT_W+1)'(CELL_IDX + 1);

  logic [KEY_W-1:0]  key_r;
  logic [DATA_W-1:0] name_r;
  logic [DATA_W-1:0] desc_r;
  logic              match_r;
  logic [CNT_W:0]    count_x;
  logic [CNT_W:0]    hit_x;
  logic              occupied;
  logic              do_append;
  logic              do_update;
  logic              do_shift;

  assign count_x  = {1'b0, count};
  assign hit_x    = (CNT_W+1)'(hit_pos);
  assign occupied = IDX < count_x;

  assign do_append = ctl.commit && (ctl.op == OP_ADD)    && (IDX == count_x);
  assign do_update = ctl.commit && (ctl.op == OP_UPDATE) && match_r;
  // entries at and after the removed slot take their upper neighbor
  assign do_shift  = ctl.commit && (ctl.op == OP_DELETE) && (IDX >= hit_x) &&
                     (NEXT < count_x);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else if (ctl.capture) begin
      match_r <= occupied && (key_r == cmd_key);
    end
  end

  always_ff @(posedge clk) begin
    if (do_append) begin
      key_r  <= cmd_key;
      name_r <= cmd_name;
      desc_r <= cmd_desc;
    end else if (do_update) begin
      name_r <= cmd_name;
      desc_r <= cmd_desc;
    end else if (do_shift) begin
      key_r  <= nb_key;
      name_r <= nb_name;
      desc_r <= nb_desc;
    end
  end

  assign key   = key_r;
  assign name  = name_r;
  assign desc  = desc_r;
  assign match = match_r;

endmodule

/* rtl/krt_resolve.sv */
// Registered OR-reduction of the one-hot match row into position and payload.
module krt_resolve #(
  parameter int DEPTH = 64,
  parameter int POS_W = 6
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic [DEPTH-1:0]           match,
  input  logic [krt_pkg::DATA_W-1:0] names [DEPTH],
  input  logic [krt_pkg::DATA_W-1:0] descs [DEPTH],
  output logic                       hit,
  output logic [POS_W-1:0]           pos,
  output logic [krt_pkg::DATA_W-1:0] name,
  output logic [krt_pkg::DATA_W-1:0] desc
);
  import krt_pkg::*;

  logic              hit_r;
  logic [POS_W-1:0]  pos_r;
  logic [DATA_W-1:0] name_r;
  logic [DATA_W-1:0] desc_r;
  logic [POS_W-1:0]  pos_c;
  logic [DATA_W-1:0] name_c;
  logic [DATA_W-1:0] desc_c;

  // keys are unique, so at most one match bit is set and a plain OR selects it
  always_comb begin
    pos_c  = '0;
    name_c = '0;
    desc_c = '0;
    for (int i = 0; i < DEPTH; i++) begin
      pos_c  = pos_c  | ({POS_W{match[i]}} & POS_W'(i));
      name_c = name_c | ({DATA_W{match[i]}} & names[i]);
      desc_c = desc_c | ({DATA_W{match[i]}} & descs[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (en) begin
      hit_r <= |match;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos_r  <= pos_c;
      name_r <= name_c;
      desc_r <= desc_c;
    end
  end

  assign hit  = hit_r;
  assign pos  = pos_r;
  assign name = name_r;
  assign desc = desc_r;

endmodule

/* rtl/keyed_record_table_compacting.sv */
// Keyed record table: dense insertion-ordered cell row with add/update/delete/find.
// The result register loads in the execute state, after the match and resolve states.
// The row's single compare/resolve/commit sequence handles one command at a time,
//   and execute waits while a result is held.
// Reset (rst_n low, synchronous): table empty, sequencer idle, no result pending.
// Stored records are not cleared; slots at or above the entry count are never read.
module keyed_record_table_compacting #(
  parameter int TABLE_DEPTH = 64
) (
  input logic       clk,
  input logic       rst_n,
  krt_in_if.sink    in_chan,
  krt_out_if.source out_chan
);
  import krt_pkg::*;

  localparam int POS_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

  // ---------------------------------------------------------------- sequencer
  state_t state_r, state_nxt;

  logic in_ready;
  logic in_xfer;
  logic capture;
  logic resolve_en;
  logic exec_go;
  logic out_valid_r;

  assign in_xfer = in_chan.valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (in_xfer) begin state_nxt = S_MATCH; end
      S_MATCH:   state_nxt = S_RESOLVE;
      S_RESOLVE: state_nxt = S_EXEC;
      S_EXEC:    if (exec_go) begin state_nxt = S_IDLE; end
      default:   state_nxt = S_IDLE;
    endcase
  end

  // execute only when the output register is free or drains this cycle
  always_comb begin
    in_ready   = 1'b0;
    capture    = 1'b0;
    resolve_en = 1'b0;
    exec_go    = 1'b0;
    unique case (state_r)
      S_IDLE:    in_ready   = 1'b1;
      S_MATCH:   capture    = 1'b1;
      S_RESOLVE: resolve_en = 1'b1;
      S_EXEC:    exec_go    = !out_valid_r || out_chan.ready;
      default:   in_ready   = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------- command latch
  op_t               op_r;
  logic [KEY_W-1:0]  key_r;
  logic [DATA_W-1:0] name_r;
  logic [DATA_W-1:0] desc_r;

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r   <= op_t'(in_chan.command);
      key_r  <= in_chan.record_key;
      name_r <= in_chan.name_data;
      desc_r <= in_chan.description_data;
    end
  end

  // ---------------------------------------------------------------- cell row
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [TABLE_DEPTH-1:0] match_vec;
  logic [KEY_W-1:0]  cell_key  [TABLE_DEPTH];
  logic [DATA_W-1:0] cell_name [TABLE_DEPTH];
  logic [DATA_W-1:0] cell_desc [TABLE_DEPTH];
  cell_ctl_t         cell_ctl;

  logic              hit;
  logic [POS_W-1:0]  hit_pos;
  logic [DATA_W-1:0] hit_name;
  logic [DATA_W-1:0] hit_desc;

  status_t           st_c;
  logic              commit;

  assign commit           = exec_go && (st_c == ST_OK);
  assign cell_ctl.op      = op_r;
  assign cell_ctl.capture = capture;
  assign cell_ctl.commit  = commit;

  // each cell hands its record to the one below for delete compaction;
  // the top cell never shifts, so its neighbor input is just its own record
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    localparam int NB = (i + 1 < TABLE_DEPTH) ? i + 1 : i;
    krt_cell #(
      .CNT_W    (CNT_W),
      .POS_W    (POS_W),
      .CELL_IDX (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (cell_ctl),
      .cmd_key  (key_r),
      .cmd_name (name_r),
      .cmd_desc (desc_r),
      .count    (count_r),
      .hit_pos  (hit_pos),
      .nb_key   (cell_key[NB]),
      .nb_name  (cell_name[NB]),
      .nb_desc  (cell_desc[NB]),
      .key      (cell_key[i]),
      .name     (cell_name[i]),
      .desc     (cell_desc[i]),
      .match    (match_vec[i])
    );
  end

  krt_resolve #(
    .DEPTH (TABLE_DEPTH),
    .POS_W (POS_W)
  ) u_resolve (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (resolve_en),
    .match (match_vec),
    .names (cell_name),
    .descs (cell_desc),
    .hit   (hit),
    .pos   (hit_pos),
    .name  (hit_name),
    .desc  (hit_desc)
  );

  // ---------------------------------------------------------------- execute
  logic [POS_W-1:0]  pos_c;
  logic [DATA_W-1:0] fname_c;
  logic [DATA_W-1:0] fdesc_c;

  always_comb begin
    st_c      = ST_OK;
    pos_c     = '0;
    fname_c   = '0;
    fdesc_c   = '0;
    count_nxt = count_r;
    unique case (op_r)
      OP_ADD: begin
        // duplicate check wins over full
        if (hit) begin
          st_c = ST_DUP;
        end else if (count_r == FULL_CNT) begin
          st_c = ST_FULL;
        end else begin
          pos_c     = POS_W'(count_r);
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_UPDATE: begin
        if (!hit) begin
          st_c = ST_NOTFOUND;
        end else begin
          pos_c = hit_pos;
        end
      end
      OP_DELETE: begin
        if (count_r == '0) begin
          st_c = ST_EMPTY;
        end else if (!hit) begin
          st_c = ST_NOTFOUND;
        end else begin
          pos_c     = hit_pos;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      OP_FIND: begin
        if (!hit) begin
          st_c = ST_NOTFOUND;
        end else begin
          pos_c   = hit_pos;
          fname_c = hit_name;
          fdesc_c = hit_desc;
        end
      end
      default: st_c = ST_NOTFOUND;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (commit) begin
      count_r <= count_nxt;
    end
  end

  // ---------------------------------------------------------------- result register
  status_t           out_status_r;
  logic [POS_W-1:0]  out_pos_r;
  logic [DATA_W-1:0] out_name_r;
  logic [DATA_W-1:0] out_desc_r;
  logic [CNT_W-1:0]  out_total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_go) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      out_status_r <= st_c;
      out_pos_r    <= pos_c;
      out_name_r   <= fname_c;
      out_desc_r   <= fdesc_c;
      out_total_r  <= count_nxt;
    end
  end

  assign in_chan.ready              = in_ready;
  assign out_chan.valid             = out_valid_r;
  assign out_chan.status            = out_status_r;
  assign out_chan.position          = out_pos_r;
  assign out_chan.found_name        = out_name_r;
  assign out_chan.found_description = out_desc_r;
  assign out_chan.entry_total       = out_total_r;

  // ---------------------------------------------------------------- assertions
  // unique keys: a compare never hits more than one cell
  a_match_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_vec))
    else $error("more than one cell matched the key");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count above table depth");

  a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EXEC))
    else $error("result raised outside execute");

  a_accept_starts_match: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == S_MATCH))
    else $error("command transfer did not start a compare");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    !commit |=> $stable(count_r))
    else $error("entry count changed without a commit");

endmodule
